// ----- rtl/ptht_pkg.sv -----
// Shared types, constants and arithmetic helpers for the pose-to-transform block.
`timescale 1ns / 1ps
package ptht_pkg;

   localparam int CORDIC_ITERS = 16;
   localparam int XY_W = 34;
   localparam int Z_W = 33;
   localparam int POS_W = 32;
   localparam int TRIG_W = 32;
   localparam int OUT_W = 16;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
      33'sh020000000, 33'sh012E4051E, 33'sh009FB385B, 33'sh0051111D4,
      33'sh0028B0D43, 33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55,
      33'sh00028BE53, 33'sh000145F2F, 33'sh0000A2F98, 33'sh0000517CC,
      33'sh000028BE6, 33'sh0000145F3, 33'sh00000A2FA, 33'sh00000517D
   };

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic [1:0]             quad;
   } axis_type;

   // One transaction moving down the CORDIC chain: roll, pitch, yaw and translation.
   typedef struct packed {
      logic                     valid;
      axis_type [2:0]           axes;
      logic signed [POS_W-1:0]  tx;
      logic signed [POS_W-1:0]  ty;
      logic signed [POS_W-1:0]  tz;
   } stage_type;

   localparam int AX_ROLL = 0;
   localparam int AX_PITCH = 1;
   localparam int AX_YAW = 2;

   typedef struct packed {
      logic                    valid;
      logic [8:0][OUT_W-1:0]   rot;
      logic signed [POS_W-1:0] tx;
      logic signed [POS_W-1:0] ty;
      logic signed [POS_W-1:0] tz;
   } result_type;

   // Splits a 32-bit binary angle into a quarter-turn count and a residual.
   function automatic axis_type prep_axis(input logic [31:0] a);
      axis_type   r;
      logic [31:0] sum;
      logic [31:0] res;
      sum = a + 32'h2000_0000;
      r.quad = sum[31:30];
      res = a - {sum[31:30], 30'd0};
      r.z = Z_W'(signed'(res));
      r.x = CORDIC_GAIN;
      r.y = '0;
      return r;
   endfunction

   // Q30 by Q30 product rounded back to Q30.
   function automatic logic signed [XY_W-1:0] qmul(input logic signed [TRIG_W-1:0] a,
                                                   input logic signed [TRIG_W-1:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd536870912;
      return p[63:30];
   endfunction

endpackage

// ----- rtl/ptht_cordic_cell.sv -----
// One CORDIC iteration for all three angles, with a register on its output.
`timescale 1ns / 1ps
module ptht_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  ptht_pkg::stage_type stage_in,
   output ptht_pkg::stage_type stage_out
);
   import ptht_pkg::*;

   stage_type stage_ff, stage_next_in;

   always_comb begin
      stage_next_in = stage_in;
      for (int k = 0; k < 3; k++) begin
         if (stage_in.axes[k].z >= 0) begin
            stage_next_in.axes[k].x = stage_in.axes[k].x - (stage_in.axes[k].y >>> SHIFT);
            stage_next_in.axes[k].y = stage_in.axes[k].y + (stage_in.axes[k].x >>> SHIFT);
            stage_next_in.axes[k].z = stage_in.axes[k].z - ATAN_TAB[SHIFT];
         end else begin
            stage_next_in.axes[k].x = stage_in.axes[k].x + (stage_in.axes[k].y >>> SHIFT);
            stage_next_in.axes[k].y = stage_in.axes[k].y - (stage_in.axes[k].x >>> SHIFT);
            stage_next_in.axes[k].z = stage_in.axes[k].z + ATAN_TAB[SHIFT];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_next_in;
      end
   end

   assign stage_out = stage_ff;
endmodule

// ----- rtl/ptht_matrix.sv -----
// Quadrant fold, rotation matrix products, rounding and saturation.
`timescale 1ns / 1ps
module ptht_matrix #(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  ptht_pkg::stage_type  stage_in,
   output ptht_pkg::result_type result
);
   import ptht_pkg::*;

   localparam int SH = 30 - TRIG_FRAC_BITS;
   localparam logic signed [XY_W:0] LIM = (XY_W+1)'(64'sd1 <<< TRIG_FRAC_BITS);

   // Fold stage.
   logic                    a_valid_ff;
   logic signed [TRIG_W-1:0] a_c_ff [3];
   logic signed [TRIG_W-1:0] a_s_ff [3];
   logic signed [POS_W-1:0] a_t_ff [3];
   logic signed [TRIG_W-1:0] a_c_in [3];
   logic signed [TRIG_W-1:0] a_s_in [3];

   // First product stage.
   logic                    b_valid_ff;
   logic signed [TRIG_W-1:0] b_p_ff [10];
   logic signed [TRIG_W-1:0] b_sp_ff;
   logic signed [TRIG_W-1:0] b_sr_ff;
   logic signed [TRIG_W-1:0] b_cr_ff;
   logic signed [POS_W-1:0] b_t_ff [3];

   // Second product stage, sums in Q30.
   logic                    c_valid_ff;
   logic signed [XY_W:0]    c_m_ff [9];
   logic signed [POS_W-1:0] c_t_ff [3];
   logic signed [XY_W:0]    c_m_in [9];

   result_type result_ff, result_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         case (stage_in.axes[k].quad)
            2'd1: begin
               a_c_in[k] = TRIG_W'(-stage_in.axes[k].y);
               a_s_in[k] = TRIG_W'(stage_in.axes[k].x);
            end
            2'd2: begin
               a_c_in[k] = TRIG_W'(-stage_in.axes[k].x);
               a_s_in[k] = TRIG_W'(-stage_in.axes[k].y);
            end
            2'd3: begin
               a_c_in[k] = TRIG_W'(stage_in.axes[k].y);
               a_s_in[k] = TRIG_W'(-stage_in.axes[k].x);
            end
            default: begin
               a_c_in[k] = TRIG_W'(stage_in.axes[k].x);
               a_s_in[k] = TRIG_W'(stage_in.axes[k].y);
            end
         endcase
      end
   end

   // Product index: 0 cy*cp, 1 cy*sp, 2 sy*sp, 3 sy*cp, 4 cp*sr, 5 cp*cr,
   // 6 sy*cr, 7 sy*sr, 8 cy*cr, 9 cy*sr.
   always_comb begin
      c_m_in[0] = (XY_W+1)'(b_p_ff[0]);
      c_m_in[1] = (XY_W+1)'(qmul(b_p_ff[1], b_sr_ff)) - (XY_W+1)'(b_p_ff[6]);
      c_m_in[2] = (XY_W+1)'(qmul(b_p_ff[1], b_cr_ff)) + (XY_W+1)'(b_p_ff[7]);
      c_m_in[3] = (XY_W+1)'(b_p_ff[3]);
      c_m_in[4] = (XY_W+1)'(qmul(b_p_ff[2], b_sr_ff)) + (XY_W+1)'(b_p_ff[8]);
      c_m_in[5] = (XY_W+1)'(qmul(b_p_ff[2], b_cr_ff)) - (XY_W+1)'(b_p_ff[9]);
      c_m_in[6] = -(XY_W+1)'(b_sp_ff);
      c_m_in[7] = (XY_W+1)'(b_p_ff[4]);
      c_m_in[8] = (XY_W+1)'(b_p_ff[5]);
   end

   always_comb begin
      logic signed [XY_W:0] v;
      result_in.valid = c_valid_ff;
      result_in.tx = c_t_ff[0];
      result_in.ty = c_t_ff[1];
      result_in.tz = c_t_ff[2];
      for (int k = 0; k < 9; k++) begin
         if (SH > 0) begin
            v = (c_m_ff[k] + ((XY_W+1)'(64'sd1 <<< (SH > 0 ? SH - 1 : 0)))) >>> SH;
         end else begin
            v = c_m_ff[k];
         end
         if (v > LIM) begin
            v = LIM;
         end else if (v < -LIM) begin
            v = -LIM;
         end
         result_in.rot[k] = v[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         result_ff.valid <= 1'b0;
      end else if (en) begin
         a_valid_ff <= stage_in.valid;
         a_c_ff <= a_c_in;
         a_s_ff <= a_s_in;
         a_t_ff[0] <= stage_in.tx;
         a_t_ff[1] <= stage_in.ty;
         a_t_ff[2] <= stage_in.tz;

         b_valid_ff <= a_valid_ff;
         b_p_ff[0] <= TRIG_W'(qmul(a_c_ff[AX_YAW], a_c_ff[AX_PITCH]));
         b_p_ff[1] <= TRIG_W'(qmul(a_c_ff[AX_YAW], a_s_ff[AX_PITCH]));
         b_p_ff[2] <= TRIG_W'(qmul(a_s_ff[AX_YAW], a_s_ff[AX_PITCH]));
         b_p_ff[3] <= TRIG_W'(qmul(a_s_ff[AX_YAW], a_c_ff[AX_PITCH]));
         b_p_ff[4] <= TRIG_W'(qmul(a_c_ff[AX_PITCH], a_s_ff[AX_ROLL]));
         b_p_ff[5] <= TRIG_W'(qmul(a_c_ff[AX_PITCH], a_c_ff[AX_ROLL]));
         b_p_ff[6] <= TRIG_W'(qmul(a_s_ff[AX_YAW], a_c_ff[AX_ROLL]));
         b_p_ff[7] <= TRIG_W'(qmul(a_s_ff[AX_YAW], a_s_ff[AX_ROLL]));
         b_p_ff[8] <= TRIG_W'(qmul(a_c_ff[AX_YAW], a_c_ff[AX_ROLL]));
         b_p_ff[9] <= TRIG_W'(qmul(a_c_ff[AX_YAW], a_s_ff[AX_ROLL]));
         b_sp_ff <= a_s_ff[AX_PITCH];
         b_sr_ff <= a_s_ff[AX_ROLL];
         b_cr_ff <= a_c_ff[AX_ROLL];
         b_t_ff <= a_t_ff;

         c_valid_ff <= b_valid_ff;
         c_m_ff <= c_m_in;
         c_t_ff <= b_t_ff;

         result_ff <= result_in;
      end
   end

   assign result = result_ff;
endmodule

// ----- rtl/pose_to_homogeneous_transform_top.sv -----
// Top level: Euler ZYX pose to the top three rows of a homogeneous transform.
//
// Usage:
//   Request channel (req_*): a pose of translation x, y, z and binary angles
//   roll, pitch, yaw. A transaction is accepted on a rising edge with
//   req_valid high and req_stall low.
//   Response channel (rsp_*): the nine rotation elements in Q1.TRIG_FRAC_BITS
//   (Rz(yaw)*Ry(pitch)*Rx(roll)) and the translation column, one response per
//   request, in order.
//   The pipeline holds one angle preparation stage, one stage per CORDIC
//   iteration (16 cells, all three angles in parallel), a quadrant fold stage,
//   two multiplier stages and a rounding/saturation stage feeding the output
//   register. Throughput is one transaction per cycle when not stalled.
//   When the receiver holds rsp_stall with a response waiting, the whole
//   pipeline freezes and req_stall is raised in the same cycle; the response
//   stays steady until taken.
//   Reset (synchronous, active high) empties the pipeline: no response is
//   valid afterwards until new requests arrive.
`timescale 1ns / 1ps
module pose_to_homogeneous_transform_top #(
   parameter int ANGLE_BITS = 16,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [ptht_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [ptht_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [ptht_pkg::POS_W-1:0] req_pos_z,
   input  logic signed [ANGLE_BITS-1:0]     req_roll_angle,
   input  logic signed [ANGLE_BITS-1:0]     req_pitch_angle,
   input  logic signed [ANGLE_BITS-1:0]     req_yaw_angle,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [ptht_pkg::OUT_W-1:0] rsp_rot_00,
   output logic signed [ptht_pkg::OUT_W-1:0] rsp_rot_01,
   output logic signed [ptht_pkg::OUT_W-1:0] rsp_rot_02,
   output logic signed [ptht_pkg::OUT_W-1:0] rsp_rot_10,
   output logic signed [ptht_pkg::OUT_W-1:0] rsp_rot_11,
   output logic signed [ptht_pkg::OUT_W-1:0] rsp_rot_12,
   output logic signed [ptht_pkg::OUT_W-1:0] rsp_rot_20,
   output logic signed [ptht_pkg::OUT_W-1:0] rsp_rot_21,
   output logic signed [ptht_pkg::OUT_W-1:0] rsp_rot_22,
   output logic signed [ptht_pkg::POS_W-1:0] rsp_trans_x,
   output logic signed [ptht_pkg::POS_W-1:0] rsp_trans_y,
   output logic signed [ptht_pkg::POS_W-1:0] rsp_trans_z
);
   import ptht_pkg::*;

   logic       advance;
   stage_type  prep_ff, prep_in;
   stage_type  chain [CORDIC_ITERS+1];
   result_type result;

   assign advance = !(result.valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      prep_in.valid = req_valid;
      prep_in.tx = req_pos_x;
      prep_in.ty = req_pos_y;
      prep_in.tz = req_pos_z;
      prep_in.axes[AX_ROLL] = prep_axis(32'(req_roll_angle) << (32 - ANGLE_BITS));
      prep_in.axes[AX_PITCH] = prep_axis(32'(req_pitch_angle) << (32 - ANGLE_BITS));
      prep_in.axes[AX_YAW] = prep_axis(32'(req_yaw_angle) << (32 - ANGLE_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (advance) begin
         prep_ff <= prep_in;
      end
   end

   assign chain[0] = prep_ff;

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cell
      ptht_cordic_cell #(
         .SHIFT(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (advance),
         .stage_in (chain[i]),
         .stage_out(chain[i+1])
      );
   end

   ptht_matrix #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_matrix (
      .clock   (clock),
      .reset   (reset),
      .en      (advance),
      .stage_in(chain[CORDIC_ITERS]),
      .result  (result)
   );

   assign rsp_valid = result.valid;
   assign rsp_rot_00 = result.rot[0];
   assign rsp_rot_01 = result.rot[1];
   assign rsp_rot_02 = result.rot[2];
   assign rsp_rot_10 = result.rot[3];
   assign rsp_rot_11 = result.rot[4];
   assign rsp_rot_12 = result.rot[5];
   assign rsp_rot_20 = result.rot[6];
   assign rsp_rot_21 = result.rot[7];
   assign rsp_rot_22 = result.rot[8];
   assign rsp_trans_x = result.tx;
   assign rsp_trans_y = result.ty;
   assign rsp_trans_z = result.tz;
endmodule

// ----- rtl/ptht_checker.sv -----
// Port-level checks for the pose-to-transform block, bound to the top level.
`timescale 1ns / 1ps
module ptht_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_rot_00,
   input logic [31:0] rsp_trans_x
);

   // The request side only stalls when a response is held back.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request accepted while response is held");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_rot_00)
                                    && $stable(rsp_trans_x)))
      else $error("stalled response changed");

endmodule

bind pose_to_homogeneous_transform_top ptht_checker u_ptht_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_rot_00 (rsp_rot_00),
   .rsp_trans_x(rsp_trans_x)
);

// ----- verif/pose_to_homogeneous_transform_top_test.sv -----
// Testbench for the pose-to-transform block: directed and random poses checked against a predictor.
`timescale 1ns / 1ps
module pose_to_homogeneous_transform_top_test;
   import ptht_pkg::*;

   typedef struct {
      logic signed [15:0] rot [9];
      logic signed [31:0] tx, ty, tz;
   } transform_type;

   typedef struct {
      logic signed [31:0] px, py, pz;
      logic signed [15:0] roll, pitch, yaw;
   } pose_type;

   localparam longint GAIN_Q30 = 652032874;
   localparam longint ARCTAN_Q30 [16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

   class transform_scoreboard;
      transform_type pending [$];
      int errors = 0;
      int checked = 0;

      function automatic longint round_q30(longint a, longint b);
         return (a * b + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function automatic void sin_cos(logic [15:0] ang, output longint s, output longint c);
         logic [31:0] a, ru;
         logic [1:0] q;
         longint x, y, z, dx, dy, t;
         a = {ang, 16'd0};
         q = 2'((a + 32'h2000_0000) >> 30);
         ru = a - {q, 30'd0};
         z = longint'(signed'(ru));
         x = GAIN_Q30;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ARCTAN_Q30[i];
            end else begin
               x += dx; y -= dy; z += ARCTAN_Q30[i];
            end
         end
         case (q)
            2'd1: begin t = x; x = -y; y = t; end
            2'd2: begin x = -x; y = -y; end
            2'd3: begin t = x; x = y; y = -t; end
            default: ;
         endcase
         c = x;
         s = y;
      endfunction

      function automatic logic signed [15:0] to_q14(longint v);
         v = (v + (64'sd1 <<< 15)) >>> 16;
         if (v > 16384) v = 16384;
         if (v < -16384) v = -16384;
         return 16'(v);
      endfunction

      function void note_pose(pose_type p);
         transform_type e;
         longint sr, cr, sp, cp, sy, cy, cysp, sysp;
         sin_cos(p.roll, sr, cr);
         sin_cos(p.pitch, sp, cp);
         sin_cos(p.yaw, sy, cy);
         cysp = round_q30(cy, sp);
         sysp = round_q30(sy, sp);
         e.rot[0] = to_q14(round_q30(cy, cp));
         e.rot[1] = to_q14(round_q30(cysp, sr) - round_q30(sy, cr));
         e.rot[2] = to_q14(round_q30(cysp, cr) + round_q30(sy, sr));
         e.rot[3] = to_q14(round_q30(sy, cp));
         e.rot[4] = to_q14(round_q30(sysp, sr) + round_q30(cy, cr));
         e.rot[5] = to_q14(round_q30(sysp, cr) - round_q30(cy, sr));
         e.rot[6] = to_q14(-sp);
         e.rot[7] = to_q14(round_q30(cp, sr));
         e.rot[8] = to_q14(round_q30(cp, cr));
         e.tx = p.px;
         e.ty = p.py;
         e.tz = p.pz;
         pending = {pending, e};
      endfunction

      function void check_transform(transform_type got);
         transform_type e;
         if (pending.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         for (int i = 0; i < 9; i++)
            if (got.rot[i] !== e.rot[i]) begin
               $display("%0t: rot_%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                        e.rot[i], got.rot[i]);
               errors++;
            end
         if (got.tx !== e.tx) begin
            $display("%0t: trans_x expected %0d actual %0d", $time, e.tx, got.tx);
            errors++;
         end
         if (got.ty !== e.ty) begin
            $display("%0t: trans_y expected %0d actual %0d", $time, e.ty, got.ty);
            errors++;
         end
         if (got.tz !== e.tz) begin
            $display("%0t: trans_z expected %0d actual %0d", $time, e.tz, got.tz);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic rsp_stall = 0;
   logic req_stall, rsp_valid;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [15:0] req_roll_angle = 0, req_pitch_angle = 0, req_yaw_angle = 0;
   logic signed [15:0] rsp_rot [9];
   logic signed [31:0] rsp_trans_x, rsp_trans_y, rsp_trans_z;

   transform_scoreboard board = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   longint cycle_count = 0;

   pose_to_homogeneous_transform_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_roll_angle(req_roll_angle), .req_pitch_angle(req_pitch_angle),
      .req_yaw_angle(req_yaw_angle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_rot_00(rsp_rot[0]), .rsp_rot_01(rsp_rot[1]), .rsp_rot_02(rsp_rot[2]),
      .rsp_rot_10(rsp_rot[3]), .rsp_rot_11(rsp_rot[4]), .rsp_rot_12(rsp_rot[5]),
      .rsp_rot_20(rsp_rot[6]), .rsp_rot_21(rsp_rot[7]), .rsp_rot_22(rsp_rot[8]),
      .rsp_trans_x(rsp_trans_x), .rsp_trans_y(rsp_trans_y), .rsp_trans_z(rsp_trans_z)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, and every accepted response goes to the scoreboard.
   always @(posedge clock) begin
      transform_type got;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         for (int i = 0; i < 9; i++) got.rot[i] = rsp_rot[i];
         got.tx = rsp_trans_x;
         got.ty = rsp_trans_y;
         got.tz = rsp_trans_z;
         board.check_transform(got);
      end
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   initial begin
      forever begin
         @(posedge clock);
         if (cycle_count > 400000) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Drives one pose and holds it until the block takes it.
   task automatic send_pose(pose_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_pos_x <= p.px;
      req_pos_y <= p.py;
      req_pos_z <= p.pz;
      req_roll_angle <= p.roll;
      req_pitch_angle <= p.pitch;
      req_yaw_angle <= p.yaw;
      do @(posedge clock); while (req_stall);
      board.note_pose(p);
   endtask

   function automatic logic [15:0] pick_angle();
      logic [15:0] specials [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                    16'h2000, 16'hE000, 16'h7FFF, 16'h8001};
      case ($urandom_range(3))
         0: return specials[$urandom_range(7)];
         1: return specials[$urandom_range(7)] + 16'($urandom_range(8)) - 16'd4;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic wait_drained();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      pose_type p;
      logic [15:0] corner [6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h2000};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: field extremes and quarter-turn boundaries on each axis.
      for (int i = 0; i < 18; i++) begin
         p.px = (i % 3 == 0) ? 32'sh7FFF_FFFF : (i % 3 == 1) ? 32'sh8000_0000 : -1;
         p.py = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         p.pz = i;
         p.roll = corner[i % 6];
         p.pitch = corner[(i / 3) % 6];
         p.yaw = corner[(i * 5) % 6];
         send_pose(p);
      end
      p = '{32'sh5555_5555, 32'shAAAA_AAAA, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      send_pose(p);
      wait_drained();
      // Random phases with different idling on each side.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 82; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 82; end
            3: begin send_idle_pct = 26; stall_pct = 26; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         for (int n = 0; n < 270; n++) begin
            p.px = $urandom;
            p.py = $urandom;
            p.pz = $urandom;
            p.roll = pick_angle();
            p.pitch = pick_angle();
            p.yaw = pick_angle();
            send_pose(p);
         end
         wait_drained();
      end
      $display("Checked %0d transforms over directed angles and five idle/stall phases.",
               board.checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
